>>> rtl/core/sdta_pkg.sv
// ----------------------------------------------------------------------------
// sdta_pkg
// Shared types, constants and a helper function for the slow-data text
// assembler.
// ----------------------------------------------------------------------------
package sdta_pkg;

    localparam int unsigned MsgLen    = 20;
    localparam int unsigned CharIdxW  = 5;
    localparam int unsigned StepW     = 4;

    localparam logic [7:0] SyncByte0  = 8'h55;
    localparam logic [7:0] SyncByte1  = 8'h2d;
    localparam logic [7:0] SyncByte2  = 8'h16;
    localparam logic [7:0] SyncFrame  = 8'h00;

    localparam logic [7:0] Scramble0  = 8'h70;
    localparam logic [7:0] Scramble1  = 8'h4f;
    localparam logic [7:0] Scramble2  = 8'h93;

    localparam logic [7:0] HeaderBase = 8'h30;

    localparam logic [StepW-1:0]    StepFirst = 4'd1;
    localparam logic [StepW-1:0]    StepLast  = 4'd8;
    localparam logic [CharIdxW-1:0] IdxLast   = CharIdxW'(MsgLen - 1);

    typedef struct packed {
        logic [7:0] frame_seq;
        logic [7:0] slow_byte0;
        logic [7:0] slow_byte1;
        logic [7:0] slow_byte2;
    } in_item_t;

    typedef struct packed {
        logic [7:0]          text_char;
        logic [CharIdxW-1:0] char_index;
        logic                last_char;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic start_run;
        logic next_char;
    } ctrl_cmd_t;

    typedef struct packed {
        logic msg_done;
        logic idx_last;
    } dp_status_t;

    // first message position written by block pair k (five characters each)
    function automatic logic [CharIdxW-1:0] block_base(input logic [1:0] k);
        logic [CharIdxW-1:0] base;
        case (k)
            2'd0:    base = 5'd0;
            2'd1:    base = 5'd5;
            2'd2:    base = 5'd10;
            2'd3:    base = 5'd15;
            default: base = 5'd0;
        endcase
        return base;
    endfunction

endpackage

>>> rtl/core/slow_data_text_assembler_top.sv
// ----------------------------------------------------------------------------
// slow_data_text_assembler_top
// Collects descrambled slow-data text over eight voice frames after a sync
// frame and reads out the 20-character message one character at a time.
//
//   channel   direction   handshake            payload
//   in        input       in_valid/in_ready    sdta_pkg::in_item_t
//   out       output      out_valid/out_ready  sdta_pkg::out_item_t
//
// a frame is taken while no readout is in progress
// the frame that completes a message starts a 20-transaction readout,
// one character per cycle when out_ready stays high
// no new frame is taken until the last character transaction completes
// reset clears the sync state and the readout; the message store is not reset
// ----------------------------------------------------------------------------
module slow_data_text_assembler_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sdta_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sdta_pkg::out_item_t   out_data
);

    sdta_pkg::ctrl_cmd_t  cmd;
    sdta_pkg::dp_status_t status;

    sdta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sdta_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

>>> rtl/core/sdta_ctrl.sv
// ----------------------------------------------------------------------------
// sdta_ctrl
// Handshake controller: takes frames while idle and steps the datapath
// through the 20-character readout once a message completes.
// ----------------------------------------------------------------------------
module sdta_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  sdta_pkg::dp_status_t   status,
    output sdta_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready      = in_ready_reg;
    assign out_valid     = out_valid_reg;
    assign cmd.accept    = in_valid && in_ready_reg;
    assign cmd.start_run = in_valid && in_ready_reg && status.msg_done;
    assign cmd.next_char = out_valid_reg && out_ready;

    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start_run)
                begin
                    state_next     = ST_EMIT;
                    in_ready_next  = 1'b0;
                    out_valid_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (cmd.next_char && status.idx_last)
                begin
                    state_next     = ST_IDLE;
                    in_ready_next  = 1'b1;
                    out_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                in_ready_next  = 1'b1;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/sdta_dp.sv
// ----------------------------------------------------------------------------
// sdta_dp
// Datapath: sync detection, step tracking, descrambling into the message
// store and the readout index.
// ----------------------------------------------------------------------------
module sdta_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdta_pkg::in_item_t     in_data,
    input  sdta_pkg::ctrl_cmd_t    cmd,
    output sdta_pkg::dp_status_t   status,
    output sdta_pkg::out_item_t    out_data
);

    logic                            armed_reg;
    logic                            armed_next;
    logic [sdta_pkg::StepW-1:0]      step_reg;
    logic [sdta_pkg::StepW-1:0]      step_next;
    logic [sdta_pkg::CharIdxW-1:0]   idx_reg;
    logic [sdta_pkg::CharIdxW-1:0]   idx_next;
    logic [7:0]                      store_reg [sdta_pkg::MsgLen];

    logic                            is_sync;
    logic                            step_hit;
    logic                            odd_step;
    logic [1:0]                      blk;
    logic                            hdr_ok;
    logic                            wr_en;
    logic [sdta_pkg::CharIdxW-1:0]   wr_base;
    logic [sdta_pkg::CharIdxW-1:0]   wr_addr1;
    logic [sdta_pkg::CharIdxW-1:0]   wr_addr2;
    logic [7:0]                      wr_data0;
    logic [7:0]                      wr_data1;
    logic [7:0]                      wr_data2;
    logic [2:0]                      even_pair;

    assign is_sync = (in_data.frame_seq == sdta_pkg::SyncFrame)
                  && (in_data.slow_byte0 == sdta_pkg::SyncByte0)
                  && (in_data.slow_byte1 == sdta_pkg::SyncByte1)
                  && (in_data.slow_byte2 == sdta_pkg::SyncByte2);

    assign step_hit  = armed_reg && (in_data.frame_seq == {4'd0, step_reg});
    assign odd_step  = step_reg[0];
    assign even_pair = 3'(step_reg[3:1] - 3'd1);
    assign blk       = odd_step ? step_reg[2:1] : even_pair[1:0];
    assign hdr_ok    = (in_data.slow_byte0 == 8'(sdta_pkg::HeaderBase + {6'd0, blk}));

    // odd steps hold a header byte, so payload starts one byte later
    assign wr_base  = odd_step ? sdta_pkg::block_base(blk)
                               : 5'(sdta_pkg::block_base(blk) + 5'd2);
    assign wr_addr1 = 5'(wr_base + 5'd1);
    assign wr_addr2 = 5'(wr_base + 5'd2);
    assign wr_data0 = odd_step ? (in_data.slow_byte1 ^ sdta_pkg::Scramble1)
                               : (in_data.slow_byte0 ^ sdta_pkg::Scramble0);
    assign wr_data1 = odd_step ? (in_data.slow_byte2 ^ sdta_pkg::Scramble2)
                               : (in_data.slow_byte1 ^ sdta_pkg::Scramble1);
    assign wr_data2 = in_data.slow_byte2 ^ sdta_pkg::Scramble2;

    assign wr_en = cmd.accept && !is_sync && step_hit && (!odd_step || hdr_ok);

    assign status.msg_done = !is_sync && step_hit && !odd_step
                          && (step_reg == sdta_pkg::StepLast);
    assign status.idx_last = (idx_reg == sdta_pkg::IdxLast);

    assign out_data.text_char  = store_reg[idx_reg];
    assign out_data.char_index = idx_reg;
    assign out_data.last_char  = (idx_reg == sdta_pkg::IdxLast);

    always_comb
    begin
        armed_next = armed_reg;
        step_next  = step_reg;
        if (cmd.accept && is_sync)
        begin
            armed_next = 1'b1;
            step_next  = sdta_pkg::StepFirst;
        end
        else if (wr_en)
        begin
            if (step_reg == sdta_pkg::StepLast)
            begin
                armed_next = 1'b0;
                step_next  = '0;
            end
            else
            begin
                step_next = 4'(step_reg + 4'd1);
            end
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.start_run)
        begin
            idx_next = '0;
        end
        else if (cmd.next_char && !status.idx_last)
        begin
            idx_next = 5'(idx_reg + 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            step_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            armed_reg <= armed_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
        end
    end

    // message store, no reset: every position is written before a readout
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_base]  <= wr_data0;
            store_reg[wr_addr1] <= wr_data1;
            if (!odd_step)
            begin
                store_reg[wr_addr2] <= wr_data2;
            end
        end
    end

endmodule

>>> rtl/core/sdta_checker.sv
// ----------------------------------------------------------------------------
// sdta_checker
// Port-level checks on the slow-data text assembler readout sequence.
// ----------------------------------------------------------------------------
module sdta_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_ready,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  sdta_pkg::out_item_t   out_data
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("frame intake open during readout");

    a_run_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (out_data.char_index == 5'd0))
        else $error("readout does not start at position zero");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last_char) |=>
            (out_valid && (out_data.char_index == 5'($past(out_data.char_index) + 5'd1))))
        else $error("readout index did not advance by one");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.last_char) |=> (!out_valid && in_ready))
        else $error("readout did not end after last character");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_char == (out_data.char_index == sdta_pkg::IdxLast)))
        else $error("last_char flag disagrees with position");

endmodule

bind slow_data_text_assembler_top sdta_checker u_sdta_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> sim/sdta_message_checker.sv
// ----------------------------------------------------------------------------
// sdta_message_checker
// Watches both channels of the slow-data text assembler. It tracks the sync
// and step state and the stored characters from the accepted frames, and
// queues the 20 characters that each completed message should read out.
// Every character transaction is compared field by field with the oldest
// queued character.
// ----------------------------------------------------------------------------
module sdta_message_checker
    import sdta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        pending,
    output int        failures
);

    logic             synced;
    logic [StepW-1:0] frame_step;
    logic [7:0]       text_store [MsgLen];
    out_item_t        queued_chars [$];
    out_item_t        want;

    task automatic absorb_frame(input in_item_t f);
        int        k;
        int        base;
        out_item_t c;
        if (f.frame_seq == SyncFrame && f.slow_byte0 == SyncByte0 &&
            f.slow_byte1 == SyncByte1 && f.slow_byte2 == SyncByte2)
        begin
            synced = 1'b1;
            frame_step = StepFirst;
            return;
        end
        if (!synced || f.frame_seq != 8'(frame_step))
            return;
        if (frame_step[0])
        begin
            k = (int'(frame_step) - 1) / 2;
            if (f.slow_byte0 != HeaderBase + 8'(k))
                return;
            base = 5 * k;
            text_store[base]     = f.slow_byte1 ^ Scramble1;
            text_store[base + 1] = f.slow_byte2 ^ Scramble2;
            frame_step = frame_step + 1'b1;
            return;
        end
        k = (int'(frame_step) - 2) / 2;
        base = 5 * k + 2;
        text_store[base]     = f.slow_byte0 ^ Scramble0;
        text_store[base + 1] = f.slow_byte1 ^ Scramble1;
        text_store[base + 2] = f.slow_byte2 ^ Scramble2;
        if (frame_step != StepLast)
        begin
            frame_step = frame_step + 1'b1;
            return;
        end
        synced = 1'b0;
        frame_step = '0;
        for (int i = 0; i < MsgLen; i++)
        begin
            c.text_char  = text_store[i];
            c.char_index = CharIdxW'(i);
            c.last_char  = (i == MsgLen - 1);
            queued_chars.push_back(c);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced = 1'b0;
            frame_step = '0;
            queued_chars.delete();
            pending = 0;
            failures = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (queued_chars.size() == 0)
                begin
                    failures++;
                    $display("%0t: character transaction with none due: expected none, actual %h",
                             $time, out_data);
                end
                else
                begin
                    want = queued_chars.pop_front();
                    if (out_data.text_char !== want.text_char)
                    begin
                        failures++;
                        $display("%0t: text_char expected %h actual %h",
                                 $time, want.text_char, out_data.text_char);
                    end
                    if (out_data.char_index !== want.char_index)
                    begin
                        failures++;
                        $display("%0t: char_index expected %0d actual %0d",
                                 $time, want.char_index, out_data.char_index);
                    end
                    if (out_data.last_char !== want.last_char)
                    begin
                        failures++;
                        $display("%0t: last_char expected %b actual %b",
                                 $time, want.last_char, out_data.last_char);
                    end
                end
            end
            if (in_valid && in_ready)
                absorb_frame(in_data);
            pending = queued_chars.size();
        end
    end

endmodule

>>> sim/slow_data_text_assembler_top_test.sv
// ----------------------------------------------------------------------------
// slow_data_text_assembler_top_test
// Drives voice frames into the slow-data text assembler: a directed part with
// sync, wrong headers, wrong frame numbers, restarts and extreme bytes, then
// random superframes with injected faults and random noise frames. Both
// handshakes idle at random except in one steady stretch. The checker beside
// the block predicts and compares the character readout.
// ----------------------------------------------------------------------------
module slow_data_text_assembler_top_test;
    import sdta_pkg::*;

    typedef enum {FILL_NUL_TEXT, FILL_RAW_ONES, FILL_RANDOM} fill_t;
    typedef enum {FAULT_FRAME_NUMBER, FAULT_HEADER, FAULT_FALSE_SYNC, FAULT_RESYNC} fault_t;

    localparam in_item_t SyncItem = {SyncFrame, SyncByte0, SyncByte1, SyncByte2};

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    int        pending;
    int        failures;
    bit        steady = 1'b0;
    int        sent_frames = 0;

    slow_data_text_assembler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    sdta_message_checker char_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .pending   (pending),
        .failures  (failures)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 26);

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    task automatic push_frame(input in_item_t f);
        while (!steady && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= f;
        do
            @(posedge clk);
        while (!in_ready);
        sent_frames++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic in_item_t step_frame(input int s, input fill_t fill);
        in_item_t f;
        case (fill)
            FILL_NUL_TEXT: f = {8'(s), Scramble0, Scramble1, Scramble2};
            FILL_RAW_ONES: f = {8'(s), 24'hffffff};
            default:       f = {8'(s), 8'($urandom), 8'($urandom), 8'($urandom)};
        endcase
        if (s % 2 == 1)
            f.slow_byte0 = HeaderBase + 8'((s - 1) / 2);
        return f;
    endfunction

    // sync plus steps 1 to 8, with faults slipped in before some steps
    task automatic send_sequence(input fill_t fill, input int fault_pct);
        int       s;
        fault_t   fault;
        in_item_t f;
        push_frame(SyncItem);
        s = 1;
        while (s <= 8)
        begin
            if ($urandom_range(99) < fault_pct)
            begin
                fault = fault_t'($urandom_range(3));
                f = step_frame(s, FILL_RANDOM);
                case (fault)
                    FAULT_FRAME_NUMBER: f.frame_seq = 8'(s) + 8'($urandom_range(1, 254));
                    FAULT_HEADER:
                        if (s % 2 == 1)
                            f.slow_byte0 = f.slow_byte0 + 8'($urandom_range(1, 255));
                        else
                            f.frame_seq = 8'(s - 1);
                    FAULT_FALSE_SYNC:
                        f = {SyncFrame, SyncByte0, SyncByte1,
                             SyncByte2 ^ 8'($urandom_range(1, 255))};
                    default:
                    begin
                        f = SyncItem;
                        s = 1;
                    end
                endcase
                push_frame(f);
            end
            push_frame(step_frame(s, fill));
            s++;
        end
    endtask

    task automatic send_noise(input int n);
        in_item_t f;
        repeat (n)
        begin
            f.frame_seq = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8));
            f.slow_byte0 = 8'($urandom);
            f.slow_byte1 = 8'($urandom);
            f.slow_byte2 = 8'($urandom);
            push_frame(f);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // not synced yet, then frame 0 without the sync pattern
        push_frame({8'd1, HeaderBase, 8'h00, 8'hff});
        push_frame({SyncFrame, SyncByte0, SyncByte1, SyncByte2 ^ 8'h01});
        // message of all-zero (NUL) characters
        send_sequence(FILL_NUL_TEXT, 0);
        // wrong header, wrong step, repeated step, top frame number
        push_frame(SyncItem);
        push_frame({8'd1, HeaderBase + 8'd1, 8'h12, 8'h34});
        push_frame({8'd2, 8'h00, 8'hff, 8'h00});
        push_frame({8'd1, HeaderBase, 8'hff, 8'h00});
        push_frame({8'd1, HeaderBase, 8'h00, 8'hff});
        push_frame({8'hff, 8'h00, 8'hff, 8'h00});
        // resync while armed, then all-ones bytes
        send_sequence(FILL_RAW_ONES, 0);
        wait_drained();

        while (sent_frames < 150)
        begin
            steady = (sent_frames >= 60 && sent_frames < 100);
            if ($urandom_range(99) < 70)
                send_sequence(FILL_RANDOM, $urandom_range(15));
            else
                send_noise($urandom_range(1, 6));
            if ($urandom_range(99) < 15)
                wait_drained();
        end
        steady = 1'b0;

        wait_drained();
        repeat (30) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
